[src/pwlm_pkg.sv]
// Package for the piecewise linear map: field widths, stream packing offsets,
// controller and divider state types. No dependencies.
`default_nettype none

package pwlm_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int VAL_W          = 16;  // breakpoint coordinates, samples, results
  localparam int PIDX_W         = 4;   // point_index field
  localparam int CNT_W          = 5;   // point_count register
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd10;

  // slave tdata layout, lowest bit first
  localparam int PIDX_LSB  = 0;
  localparam int PIN_LSB   = PIDX_LSB + PIDX_W;
  localparam int POUT_LSB  = PIN_LSB + VAL_W;
  localparam int SMP_LSB   = POUT_LSB + VAL_W;
  localparam int FIELDS_W  = SMP_LSB + VAL_W;
  localparam int S_TDATA_W = ((FIELDS_W + 7) / 8) * 8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // divider: one quotient bit per step
  localparam int DIV_STEPS = VAL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_CHK0,
    ST_RDL,
    ST_CHKL,
    ST_RDP,
    ST_CHKP,
    ST_DIV,
    ST_RES
  } pwlm_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_STEP,
    DV_DONE
  } pwlm_div_state_e;

endpackage

`default_nettype wire

[src/pwlm_muldiv.sv]
// Multiply-then-divide unit: floor(dx * mag / den) with dx < den.
// A multiply step, then one restoring quotient bit per cycle. Uses pwlm_pkg.
`default_nettype none

module pwlm_muldiv
  import pwlm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [VAL_W-1:0] dx_i,
  input  wire logic [VAL_W-1:0] mag_i,
  input  wire logic [VAL_W-1:0] den_i,
  output logic                  done_o,
  output logic [VAL_W-1:0]      quot_o
);

  pwlm_div_state_e state_q, state_d;

  logic [VAL_W-1:0]   a_q, b_q, den_q;
  logic [VAL_W-1:0]   rem_q, rem_d;
  logic [VAL_W-1:0]   lo_q, lo_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic [2*VAL_W-1:0] prod;
  logic [VAL_W:0]     trial;
  logic [VAL_W:0]     diff;
  logic               ge;
  logic               last_step;

  assign last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i) state_d = DV_MUL;
      DV_MUL:  state_d = DV_STEP;
      DV_STEP: if (last_step) state_d = DV_DONE;
      DV_DONE: state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  // datapath; since dx < den the high product half is already below den
  always_comb begin
    prod  = a_q * b_q;
    trial = {rem_q, lo_q[VAL_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = rem_q;
    lo_d  = lo_q;
    cnt_d = cnt_q;
    unique case (state_q)
      DV_MUL: begin
        rem_d = prod[2*VAL_W-1:VAL_W];
        lo_d  = prod[VAL_W-1:0];
        cnt_d = '0;
      end
      DV_STEP: begin
        rem_d = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
        lo_d  = {lo_q[VAL_W-2:0], ge};
        cnt_d = cnt_q + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    done_o = (state_q == DV_DONE);
    quot_o = lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      a_q   <= dx_i;
      b_q   <= mag_i;
      den_q <= den_i;
    end
    rem_q <= rem_d;
    lo_q  <= lo_d;
    cnt_q <= cnt_d;
  end

endmodule

`default_nettype wire

[src/piecewise_linear_map_top.sv]
// Piecewise linear map, top level: breakpoint table, search sequencer, output
// register. Uses pwlm_pkg and pwlm_muldiv.
//
// A load request (tuser = 0) writes one (input, output) breakpoint pair into
// the table slot point_index and gives no result; slots at or beyond
// MAX_POINTS are ignored. A convert request (tuser = 1) maps sample through
// the first N = point_count breakpoints (N held to 2..MAX_POINTS): clamps
// below the first and above the last breakpoint, returns the output of an
// exact hit, and otherwise interpolates the segment with truncating
// division. The input side is busy for the whole convert: the single-port
// table is read one entry at a time (first, last, then a forward scan), and
// the multiply/divide unit then gives one quotient bit per step. A clamped
// sample returns after the first or last read; the worst case scans the
// whole table and then divides. A finished result sits in an output register
// so the next request is taken while it waits. Table contents are undefined
// until written; point_count resets to 10. point_count is to be written on
// the cfg channel only while the block is idle; the block does not enforce it.
`default_nettype none

module piecewise_linear_map_top
  import pwlm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request stream
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: point_index[3:0], point_in[19:4], point_out[35:20], sample[51:36], zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: op (0 load, 1 convert)
  input  wire logic                 s_axis_tuser_i,
  // result stream
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata: mapped_value[15:0]
  output logic [VAL_W-1:0]          m_axis_tdata_o,
  // point_count register write
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CNT_W-1:0]     cfg_data_i
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [7:0] MAX8 = 8'(MAX_POINTS);

  // ---------------------------------------------------------------- fields
  logic [PIDX_W-1:0] f_pidx;
  logic [VAL_W-1:0]  f_pin, f_pout, f_smp;

  assign f_pidx = s_axis_tdata_i[PIDX_LSB +: PIDX_W];
  assign f_pin  = s_axis_tdata_i[PIN_LSB  +: VAL_W];
  assign f_pout = s_axis_tdata_i[POUT_LSB +: VAL_W];
  assign f_smp  = s_axis_tdata_i[SMP_LSB  +: VAL_W];

  // ---------------------------------------------------------------- state
  pwlm_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q;
  logic [VAL_W-1:0] sample_q, sample_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] x0_q, x0_d, y0_q, y0_d;
  logic [VAL_W-1:0] res_q, res_d;
  logic             down_q, down_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_data_q;

  logic req_acc, req_conv, req_load;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign req_conv = req_acc && (s_axis_tuser_i == OP_CONVERT);
  assign req_load = req_acc && (s_axis_tuser_i == OP_LOAD);

  // used point count, held to 2..MAX_POINTS, as index of the last breakpoint
  logic [7:0] cnt8, n8, last8;
  always_comb begin
    cnt8 = {{(8-CNT_W){1'b0}}, count_q};
    if (cnt8 < 8'd2) begin
      n8 = 8'd2;
    end else if (cnt8 > MAX8) begin
      n8 = MAX8;
    end else begin
      n8 = cnt8;
    end
    last8 = n8 - 8'd1;
  end

  // ---------------------------------------------------------------- table
  // entry = {input coordinate, output value}
  logic [2*VAL_W-1:0] mem [MAX_POINTS];
  logic [2*VAL_W-1:0] rdata_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  assign wr_en   = req_load && ({{(8-PIDX_W){1'b0}}, f_pidx} < MAX8);
  assign wr_addr = IDX_W'(f_pidx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {f_pin, f_pout};
    end
    rdata_q <= mem[idx_q];
  end

  logic [VAL_W-1:0] rd_x, rd_y;
  assign rd_x = rdata_q[2*VAL_W-1:VAL_W];
  assign rd_y = rdata_q[VAL_W-1:0];

  // ---------------------------------------------------------------- divider
  logic             div_start, div_done;
  logic [VAL_W-1:0] div_dx, div_mag, div_den, div_quot;

  assign div_dx  = sample_q - x0_q;
  assign div_den = rd_x - x0_q;
  assign div_mag = (rd_y < y0_q) ? (y0_q - rd_y) : (rd_y - y0_q);

  pwlm_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dx_i    (div_dx),
    .mag_i   (div_mag),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- sequencer
  logic scan_stop, hit, res_load;
  assign scan_stop = (idx_q == last_q) || (sample_q <= rd_x);
  assign hit       = (sample_q == rd_x);
  assign res_load  = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_conv) state_d = ST_RD0;
      ST_RD0:  state_d = ST_CHK0;
      ST_CHK0: state_d = (sample_q <= rd_x) ? ST_RES : ST_RDL;
      ST_RDL:  state_d = ST_CHKL;
      ST_CHKL: state_d = (sample_q >= rd_x) ? ST_RES : ST_RDP;
      ST_RDP:  state_d = ST_CHKP;
      ST_CHKP: begin
        if (!scan_stop) begin
          state_d = ST_RDP;
        end else if (hit) begin
          state_d = ST_RES;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_d = ST_RES;
      ST_RES:  if (res_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and controls
  always_comb begin
    sample_d  = sample_q;
    last_d    = last_q;
    idx_d     = idx_q;
    x0_d      = x0_q;
    y0_d      = y0_q;
    res_d     = res_q;
    down_d    = down_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_conv) begin
          sample_d = f_smp;
          last_d   = last8[IDX_W-1:0];
          idx_d    = '0;
        end
      end
      ST_CHK0: begin
        x0_d  = rd_x;
        y0_d  = rd_y;
        res_d = rd_y;
        idx_d = last_q;
      end
      ST_CHKL: begin
        res_d = rd_y;
        idx_d = IDX_W'(1);
      end
      ST_CHKP: begin
        res_d = rd_y;
        if (!scan_stop) begin
          x0_d  = rd_x;
          y0_d  = rd_y;
          idx_d = idx_q + IDX_W'(1);
        end else if (!hit) begin
          div_start = 1'b1;
          down_d    = (rd_y < y0_q);
        end
      end
      ST_DIV: begin
        res_d = down_q ? (y0_q - div_quot) : (y0_q + div_quot);
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_RES && res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= CNT_RESET;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    last_q   <= last_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    res_q    <= res_d;
    down_q   <= down_d;
    if (state_q == ST_RES && res_load) begin
      out_data_q <= res_q;
    end
  end

endmodule

`default_nettype wire

[src/pwlm_checker.sv]
// Port-level checks for piecewise_linear_map_top, bound to the top level.
// Uses pwlm_pkg.
`default_nettype none

module pwlm_checker
  import pwlm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 s_axis_tuser_i,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [VAL_W-1:0]     m_axis_tdata_o
);

  // a convert request holds off the next request
  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_CONVERT)
      |=> !s_axis_tready_o)
    else $error("ready after convert request");

  // a load completes in its own cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OP_LOAD)
      |=> s_axis_tready_o)
    else $error("not ready after load request");

  // a new result appears only at the end of a convert
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without convert in progress");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_map_top pwlm_checker u_pwlm_checker (.*);

`default_nettype wire
